@@ rtl/core/sm83_load_alu_execute_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the SM83 load/ALU execute core checker
// ---------------------------------------------------------------------------
`ifndef SM83_LOAD_ALU_EXECUTE_CORE_MACROS_SVH
`define SM83_LOAD_ALU_EXECUTE_CORE_MACROS_SVH

// a implies b on the same edge; expects clock and reset in scope
`define SM83_ASSERT_IMP(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("same-cycle property failed");

// a implies b on the next edge; expects clock and reset in scope
`define SM83_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("next-cycle property failed");

`endif

@@ rtl/core/sm83_pkg.sv @@
// ---------------------------------------------------------------------------
// SM83 execute package
// Shared types for the SM83 load/ALU execute core.
// ---------------------------------------------------------------------------
package sm83_pkg;

   typedef struct packed {
      logic [7:0]  a;
      logic [3:0]  f;
      logic [15:0] bc;
      logic [15:0] de;
      logic [15:0] hl;
      logic [15:0] sp;
   } arch_state_type;

   typedef struct packed {
      arch_state_type st;
      logic [15:0]    mem_addr;
      logic           mem_rd;
      logic           mem_we;
      logic           mem_wide;
      logic [15:0]    mem_wdata;
      logic           illegal;
   } exec_result_type;

   localparam logic [7:0] OP_NOP  = 8'h00;
   localparam logic [7:0] OP_HALT = 8'h76;
   localparam logic [7:0] OP_LD_NN_SP = 8'h08;
   localparam logic [7:0] OP_LDH_N_A  = 8'he0;
   localparam logic [7:0] OP_LDH_C_A  = 8'he2;
   localparam logic [7:0] OP_LD_NN_A  = 8'hea;
   localparam logic [7:0] OP_LDH_A_N  = 8'hf0;
   localparam logic [7:0] OP_LDH_A_C  = 8'hf2;
   localparam logic [7:0] OP_LD_A_NN  = 8'hfa;
   localparam logic [7:0] OP_ADD_SP_E = 8'he8;
   localparam logic [7:0] OP_LD_HL_SPE = 8'hf8;
   localparam logic [7:0] OP_LD_SP_HL = 8'hf9;
   localparam logic [15:0] HIGH_PAGE = 16'hff00;

endpackage

@@ rtl/core/sm83_exec.sv @@
// ---------------------------------------------------------------------------
// SM83 execute logic
// Decodes one opcode and computes next state and memory access.
// ---------------------------------------------------------------------------
module sm83_exec
   import sm83_pkg::*;
(
   input  arch_state_type  cur,
   input  logic [7:0]      cmd,
   input  logic [15:0]     imm,
   input  logic [15:0]     mem_rdata,
   output exec_result_type res
);

   function automatic logic [7:0] get_r(arch_state_type s, logic [2:0] r, logic [7:0] mb);
      logic [7:0] v;
      case (r)
         3'd0: v = s.bc[15:8];
         3'd1: v = s.bc[7:0];
         3'd2: v = s.de[15:8];
         3'd3: v = s.de[7:0];
         3'd4: v = s.hl[15:8];
         3'd5: v = s.hl[7:0];
         3'd6: v = mb;
         default: v = s.a;
      endcase
      return v;
   endfunction

   function automatic arch_state_type set_r(arch_state_type s, logic [2:0] r, logic [7:0] v);
      arch_state_type o;
      o = s;
      case (r)
         3'd0: o.bc[15:8] = v;
         3'd1: o.bc[7:0] = v;
         3'd2: o.de[15:8] = v;
         3'd3: o.de[7:0] = v;
         3'd4: o.hl[15:8] = v;
         3'd5: o.hl[7:0] = v;
         3'd7: o.a = v;
         default: o = s;
      endcase
      return o;
   endfunction

   function automatic logic [15:0] get_p(arch_state_type s, logic [1:0] p);
      logic [15:0] v;
      case (p)
         2'd0: v = s.bc;
         2'd1: v = s.de;
         2'd2: v = s.hl;
         default: v = s.sp;
      endcase
      return v;
   endfunction

   function automatic arch_state_type set_p(arch_state_type s, logic [1:0] p, logic [15:0] v);
      arch_state_type o;
      o = s;
      case (p)
         2'd0: o.bc = v;
         2'd1: o.de = v;
         2'd2: o.hl = v;
         default: o.sp = v;
      endcase
      return o;
   endfunction

   logic [2:0]  hi, lo;
   logic [1:0]  pi;
   logic [7:0]  rb, n, alu_src, srcv, idv, idr;
   logic [8:0]  add9, sub9;
   logic [4:0]  addh, subh;
   logic        cin;
   logic [7:0]  alu_res;
   logic [3:0]  alu_f;
   logic [16:0] hl_sum;
   logic [12:0] hl_h;
   logic [15:0] spe;
   logic [3:0]  spe_f;
   logic [8:0]  spe_c;
   logic [4:0]  spe_h;
   logic [15:0] pair_v;

   assign hi = cmd[5:3];
   assign lo = cmd[2:0];
   assign pi = cmd[5:4];
   assign rb = mem_rdata[7:0];
   assign n  = imm[7:0];
   assign srcv = get_r(cur, lo, rb);
   assign alu_src = cmd[7:6] == 2'b11 ? n : srcv;
   assign pair_v = get_p(cur, pi);

   // 8-bit ALU
   always_comb begin
      cin = 1'b0;
      if (hi == 3'd1 || hi == 3'd3) cin = cur.f[0];
      add9 = {1'b0, cur.a} + {1'b0, alu_src} + {8'd0, cin};
      addh = {1'b0, cur.a[3:0]} + {1'b0, alu_src[3:0]} + {4'd0, cin};
      sub9 = {1'b0, cur.a} - {1'b0, alu_src} - {8'd0, cin};
      subh = {1'b0, cur.a[3:0]} - {1'b0, alu_src[3:0]} - {4'd0, cin};
      case (hi)
         3'd0, 3'd1: begin
            alu_res = add9[7:0];
            alu_f = {add9[7:0] == 8'd0, 1'b0, addh[4], add9[8]};
         end
         3'd2, 3'd3, 3'd7: begin
            alu_res = sub9[7:0];
            alu_f = {sub9[7:0] == 8'd0, 1'b1, subh[4], sub9[8]};
         end
         3'd4: begin
            alu_res = cur.a & alu_src;
            alu_f = {alu_res == 8'd0, 3'b010};
         end
         3'd5: begin
            alu_res = cur.a ^ alu_src;
            alu_f = {alu_res == 8'd0, 3'b000};
         end
         default: begin
            alu_res = cur.a | alu_src;
            alu_f = {alu_res == 8'd0, 3'b000};
         end
      endcase
   end

   assign idv = get_r(cur, hi, rb);
   assign idr = lo[0] ? idv - 8'd1 : idv + 8'd1;
   assign hl_sum = {1'b0, cur.hl} + {1'b0, pair_v};
   assign hl_h = {1'b0, cur.hl[11:0]} + {1'b0, pair_v[11:0]};
   assign spe = cur.sp + {{8{n[7]}}, n};
   assign spe_c = {1'b0, cur.sp[7:0]} + {1'b0, n};
   assign spe_h = {1'b0, cur.sp[3:0]} + {1'b0, n[3:0]};
   assign spe_f = {2'b00, spe_h[4], spe_c[8]};

   always_comb begin
      res = '0;
      res.st = cur;
      if (cmd[7:6] == 2'b01 && cmd != OP_HALT) begin
         if (lo == 3'd6) begin
            res.mem_rd = 1'b1;
            res.mem_addr = cur.hl;
         end
         if (hi == 3'd6) begin
            res.mem_we = 1'b1;
            res.mem_addr = cur.hl;
            res.mem_wdata = {8'd0, srcv};
         end else begin
            res.st = set_r(cur, hi, srcv);
         end
      end else if (cmd[7:6] == 2'b10 || (cmd[7:6] == 2'b11 && lo == 3'd6)) begin
         if (cmd[7:6] == 2'b10 && lo == 3'd6) begin
            res.mem_rd = 1'b1;
            res.mem_addr = cur.hl;
         end
         res.st.f = alu_f;
         if (hi != 3'd7) res.st.a = alu_res;
      end else if (cmd[7:6] == 2'b00 && lo == 3'd6) begin
         if (hi == 3'd6) begin
            res.mem_we = 1'b1;
            res.mem_addr = cur.hl;
            res.mem_wdata = {8'd0, n};
         end else begin
            res.st = set_r(cur, hi, n);
         end
      end else if (cmd[7:6] == 2'b00 && (lo == 3'd4 || lo == 3'd5)) begin
         res.st.f = {idr == 8'd0, lo[0],
                     lo[0] ? idv[3:0] == 4'h0 : idv[3:0] == 4'hf, cur.f[0]};
         if (hi == 3'd6) begin
            res.mem_rd = 1'b1;
            res.mem_we = 1'b1;
            res.mem_addr = cur.hl;
            res.mem_wdata = {8'd0, idr};
         end else begin
            res.st = set_r(res.st, hi, idr);
         end
      end else if (cmd[7:6] == 2'b00 && cmd[3:0] == 4'h1) begin
         res.st = set_p(cur, pi, imm);
      end else if (cmd[7:6] == 2'b00 && cmd[3:0] == 4'h3) begin
         res.st = set_p(cur, pi, pair_v + 16'd1);
      end else if (cmd[7:6] == 2'b00 && cmd[3:0] == 4'hb) begin
         res.st = set_p(cur, pi, pair_v - 16'd1);
      end else if (cmd[7:6] == 2'b00 && cmd[3:0] == 4'h9) begin
         res.st.hl = hl_sum[15:0];
         res.st.f = {cur.f[3], 1'b0, hl_h[12], hl_sum[16]};
      end else if (cmd[7:6] == 2'b00 && (cmd[3:0] == 4'h2 || cmd[3:0] == 4'ha)) begin
         res.mem_addr = pi == 2'd3 ? cur.hl : pair_v;
         if (cmd[3]) begin
            res.mem_rd = 1'b1;
            res.st.a = rb;
         end else begin
            res.mem_we = 1'b1;
            res.mem_wdata = {8'd0, cur.a};
         end
         if (pi == 2'd2) res.st.hl = cur.hl + 16'd1;
         if (pi == 2'd3) res.st.hl = cur.hl - 16'd1;
      end else if (cmd == OP_LD_NN_SP) begin
         res.mem_we = 1'b1;
         res.mem_wide = 1'b1;
         res.mem_addr = imm;
         res.mem_wdata = cur.sp;
      end else if (cmd[7:6] == 2'b11 && cmd[3:0] == 4'h5) begin
         res.st.sp = cur.sp - 16'd2;
         res.mem_we = 1'b1;
         res.mem_wide = 1'b1;
         res.mem_addr = cur.sp - 16'd2;
         res.mem_wdata = pi == 2'd3 ? {cur.a, cur.f, 4'h0} : pair_v;
      end else if (cmd[7:6] == 2'b11 && cmd[3:0] == 4'h1) begin
         res.mem_rd = 1'b1;
         res.mem_wide = 1'b1;
         res.mem_addr = cur.sp;
         res.st.sp = cur.sp + 16'd2;
         if (pi == 2'd3) begin
            res.st.a = mem_rdata[15:8];
            res.st.f = mem_rdata[7:4];
         end else begin
            res.st = set_p(res.st, pi, mem_rdata);
         end
      end else if (cmd == OP_LDH_N_A || cmd == OP_LDH_C_A || cmd == OP_LD_NN_A) begin
         res.mem_we = 1'b1;
         res.mem_wdata = {8'd0, cur.a};
         res.mem_addr = cmd == OP_LD_NN_A ? imm :
                        HIGH_PAGE | {8'd0, cmd == OP_LDH_N_A ? n : cur.bc[7:0]};
      end else if (cmd == OP_LDH_A_N || cmd == OP_LDH_A_C || cmd == OP_LD_A_NN) begin
         res.mem_rd = 1'b1;
         res.st.a = rb;
         res.mem_addr = cmd == OP_LD_A_NN ? imm :
                        HIGH_PAGE | {8'd0, cmd == OP_LDH_A_N ? n : cur.bc[7:0]};
      end else if (cmd == OP_ADD_SP_E) begin
         res.st.sp = spe;
         res.st.f = spe_f;
      end else if (cmd == OP_LD_HL_SPE) begin
         res.st.hl = spe;
         res.st.f = spe_f;
      end else if (cmd == OP_LD_SP_HL) begin
         res.st.sp = cur.hl;
      end else if (cmd != OP_NOP) begin
         res.illegal = 1'b1;
      end
   end

endmodule

@@ rtl/core/sm83_load_alu_execute_core.sv @@
// Accepted request enters the input register, then the result register that drives rsp_valid.
// Throughput: one item per cycle while rsp_stall is low; input fills while the result waits.
// Architectural state updates as the staged item moves out, so back-to-back items chain.
// Reset: synchronous, active high; A, flags, BC, DE, HL and SP clear to zero.
// ---------------------------------------------------------------------------
// SM83 load/ALU execute core
// Input register, single-pass execute, result register.
// ---------------------------------------------------------------------------
module sm83_load_alu_execute_core
   import sm83_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_cmd,
   input  logic [15:0] req_imm,
   input  logic [15:0] req_mem_rdata,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_acc,
   output logic [3:0]  rsp_flag_bits,
   output logic [15:0] rsp_pair_bc,
   output logic [15:0] rsp_pair_de,
   output logic [15:0] rsp_pair_hl,
   output logic [15:0] rsp_stack_ptr,
   output logic [15:0] rsp_mem_addr,
   output logic        rsp_mem_rd,
   output logic        rsp_mem_we,
   output logic        rsp_mem_wide,
   output logic [15:0] rsp_mem_wdata,
   output logic        rsp_illegal
);

   logic            in_vld_ff, in_vld_in;
   logic [7:0]      cmd_ff;
   logic [15:0]     imm_ff, rdata_ff;
   logic            out_vld_ff, out_vld_in;
   exec_result_type out_ff;
   arch_state_type  arch_ff;
   exec_result_type ex;
   logic            adv;

   // state advances when the staged item moves to the result register
   assign adv = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !adv;
   assign in_vld_in = (req_valid && !req_stall) || (in_vld_ff && !adv);
   assign out_vld_in = adv || (out_vld_ff && rsp_stall);

   sm83_exec u_exec (
      .cur       (arch_ff),
      .cmd       (cmd_ff),
      .imm       (imm_ff),
      .mem_rdata (rdata_ff),
      .res       (ex)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         arch_ff <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (adv) arch_ff <= ex.st;
      end
      if (req_valid && !req_stall) begin
         cmd_ff <= req_cmd;
         imm_ff <= req_imm;
         rdata_ff <= req_mem_rdata;
      end
      if (adv) out_ff <= ex;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_acc = out_ff.st.a;
   assign rsp_flag_bits = out_ff.st.f;
   assign rsp_pair_bc = out_ff.st.bc;
   assign rsp_pair_de = out_ff.st.de;
   assign rsp_pair_hl = out_ff.st.hl;
   assign rsp_stack_ptr = out_ff.st.sp;
   assign rsp_mem_addr = out_ff.mem_addr;
   assign rsp_mem_rd = out_ff.mem_rd;
   assign rsp_mem_we = out_ff.mem_we;
   assign rsp_mem_wide = out_ff.mem_wide;
   assign rsp_mem_wdata = out_ff.mem_wdata;
   assign rsp_illegal = out_ff.illegal;

endmodule

@@ rtl/core/sm83_checker.sv @@
// ---------------------------------------------------------------------------
// SM83 execute core checker
// Port-level properties, bound to the top level.
// ---------------------------------------------------------------------------
`include "sm83_load_alu_execute_core_macros.svh"
module sm83_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_mem_rd,
   input logic        rsp_mem_we,
   input logic        rsp_mem_wide,
   input logic        rsp_illegal,
   input logic [15:0] rsp_mem_addr,
   input logic [15:0] rsp_mem_wdata
);

   `SM83_ASSERT_IMP(a_illegal_no_mem, rsp_valid && rsp_illegal, !rsp_mem_rd && !rsp_mem_we)
   `SM83_ASSERT_IMP(a_wide_has_access, rsp_valid && rsp_mem_wide, rsp_mem_rd != rsp_mem_we)
   `SM83_ASSERT_IMP(a_no_write_no_data, rsp_valid && !rsp_mem_we, rsp_mem_wdata == 16'd0)
   `SM83_ASSERT_NEXT(a_stall_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_mem_addr))

endmodule

bind sm83_load_alu_execute_core sm83_checker u_sm83_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_mem_rd    (rsp_mem_rd),
   .rsp_mem_we    (rsp_mem_we),
   .rsp_mem_wide  (rsp_mem_wide),
   .rsp_illegal   (rsp_illegal),
   .rsp_mem_addr  (rsp_mem_addr),
   .rsp_mem_wdata (rsp_mem_wdata)
);
